FILE: sv/wfpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes, codes and constant tables of the windowed FFT power accumulator.
// Window and twiddle tables are built at elaboration by a fixed-point CORDIC.
// No dependencies.
package wfpa_pkg;

    localparam int FFT_SIZE = 1024;
    localparam int LOG_SIZE = $clog2(FFT_SIZE);
    localparam int HALF     = FFT_SIZE / 2;
    localparam int BINS     = HALF + 1;
    localparam int IDX_W    = LOG_SIZE;
    localparam int HALF_W   = LOG_SIZE - 1;
    localparam int STAGE_W  = $clog2(LOG_SIZE);
    localparam int SUM_W    = 16 + LOG_SIZE;
    localparam int BIN_W    = 10;
    localparam int POW_W    = 63;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);
    localparam int CORDIC_STEPS = 20;

    // window angle step of one turn over FFT_SIZE-1, as quotient and remainder
    localparam longint WIN_DEN    = longint'(FFT_SIZE - 1);
    localparam longint WIN_STEP_Q = (64'sd1 <<< 32) / WIN_DEN;
    localparam longint WIN_STEP_R = (64'sd1 <<< 32) % WIN_DEN;

    localparam logic [1:0] FUNC_PUSH  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] WIN_HANN    = 2'd0;
    localparam logic [1:0] WIN_HAMMING = 2'd1;
    localparam logic [1:0] WIN_BH      = 2'd2;

    localparam logic [POW_W-1:0] POWER_MAX = {POW_W{1'b1}};

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_READ,
        OP_READ_ZERO,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [15:0] sample;
        logic [BIN_W-1:0]  bin_index;
    } in_item_t;

    typedef struct packed {
        logic [POW_W-1:0] power;
        logic             saturated;
    } out_item_t;

    typedef struct packed {
        op_t              op;
        logic [15:0]      sample;
        logic [IDX_W-1:0] bin;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } cmd_t;

    typedef struct packed {
        logic take;
        logic init_busy;
    } back_stat_t;

    typedef logic [FFT_SIZE-1:0][16:0] win_tab_t;
    typedef logic [HALF-1:0][33:0]     tw_tab_t;

    function automatic longint atan_turn(int k);
        longint a;
        unique case (k)
            0:  a = 64'h20000000;
            1:  a = 64'h12E4051E;
            2:  a = 64'h09FB385B;
            3:  a = 64'h051111D4;
            4:  a = 64'h028B0D43;
            5:  a = 64'h0145D7E1;
            6:  a = 64'h00A2F61E;
            7:  a = 64'h00517C55;
            8:  a = 64'h0028BE53;
            9:  a = 64'h00145F2F;
            10: a = 64'h000A2F98;
            11: a = 64'h000517CC;
            12: a = 64'h00028BE6;
            13: a = 64'h000145F3;
            14: a = 64'h0000A2FA;
            15: a = 64'h0000517D;
            16: a = 64'h000028BE;
            17: a = 64'h0000145F;
            18: a = 64'h00000A30;
            default: a = 64'h00000518;
        endcase
        return a;
    endfunction

    // cosine of a binary angle, one turn = 2^32, result Q2.30
    function automatic longint cos30(logic [31:0] t_in);
        logic [31:0] t;
        logic [31:0] tq;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      xs;
        longint      ys;
        tq   = t_in + 32'h4000_0000;
        flip = tq[31];
        t    = flip ? t_in + 32'h8000_0000 : t_in;
        x    = 64'sd652032874;
        y    = 64'sd0;
        z    = longint'($signed(t));
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_turn(k);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_turn(k);
            end
        end
        return flip ? -x : x;
    endfunction

    function automatic longint clamp64(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [16:0] q15_of(longint v30);
        longint r;
        r = clamp64((v30 + 64'sd16384) >>> 15, -64'sd32768, 64'sd32768);
        return 17'(r);
    endfunction

    function automatic win_tab_t build_win(logic [1:0] kind);
        win_tab_t    tab;
        logic [31:0] t;
        longint      c1;
        longint      c2;
        longint      c3;
        longint      acc;
        longint      r;
        longint      ang_q;
        longint      ang_r;
        ang_q = 0;
        ang_r = 0;
        for (int i = 0; i < FFT_SIZE; i++) begin
            t  = 32'(ang_q);
            c1 = cos30(t);
            c2 = cos30(32'(t * 32'd2));
            c3 = cos30(32'(t * 32'd3));
            unique case (kind)
                WIN_HAMMING: acc = 64'sd579820585 * 64'sd1073741824 - 64'sd493921239 * c1;
                WIN_BH:      acc = 64'sd385204879 * 64'sd1073741824 - 64'sd524297395 * c1
                                 + 64'sd151698245 * c2 - 64'sd12541305 * c3;
                default:     acc = 64'sd536870912 * 64'sd1073741824 - 64'sd536870912 * c1;
            endcase
            r = clamp64((acc + (64'sd1 <<< 44)) >>> 45, 64'sd0, 64'sd32768);
            tab[i] = 17'(r);
            // advance the angle, carrying the remainder
            ang_r = ang_r + WIN_STEP_R;
            ang_q = ang_q + WIN_STEP_Q;
            if (ang_r >= WIN_DEN) begin
                ang_r = ang_r - WIN_DEN;
                ang_q = ang_q + 1;
            end
        end
        return tab;
    endfunction

    function automatic tw_tab_t build_tw();
        tw_tab_t     tab;
        logic [31:0] t;
        for (int i = 0; i < HALF; i++) begin
            t = 32'(longint'(i) <<< (32 - LOG_SIZE));
            tab[i] = {q15_of(cos30(t)), q15_of(cos30(t + 32'h4000_0000))};
        end
        return tab;
    endfunction

    localparam win_tab_t WIN_HANN_TAB    = build_win(WIN_HANN);
    localparam win_tab_t WIN_HAMMING_TAB = build_win(WIN_HAMMING);
    localparam win_tab_t WIN_BH_TAB      = build_win(WIN_BH);
    localparam tw_tab_t  TW_TAB          = build_tw();

    function automatic logic [16:0] win_at(logic [1:0] kind, logic [IDX_W-1:0] idx);
        logic [16:0] w;
        unique case (kind)
            WIN_HAMMING: w = WIN_HAMMING_TAB[idx];
            WIN_BH:      w = WIN_BH_TAB[idx];
            default:     w = WIN_HANN_TAB[idx];
        endcase
        return w;
    endfunction

    function automatic logic [IDX_W-1:0] bit_rev(logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        for (int k = 0; k < IDX_W; k++) begin
            r[k] = v[IDX_W-1-k];
        end
        return r;
    endfunction

endpackage

FILE: sv/wfpa_front.sv
`timescale 1ns / 1ps
// Front end: takes input words, decodes the function code and queues commands.
// Depends on wfpa_pkg.
module wfpa_front
    import wfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    input  back_stat_t stat,
    output cmd_t       cmd
);

    cmd_entry_t         q_reg [QDEPTH];
    logic [QPTR_W-1:0]  head_reg;
    logic [QPTR_W-1:0]  head_next;
    logic [QPTR_W-1:0]  tail_reg;
    logic [QPTR_W-1:0]  tail_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               accept;
    logic               keep;
    logic               enq;
    logic               deq;
    cmd_entry_t         entry_new;

    assign full   = (count_reg == QCNT_W'(QDEPTH)) || stat.init_busy;
    assign accept = push && !full;

    always_comb
    begin
        keep = 1'b1;
        entry_new.sample = item.sample;
        entry_new.bin    = IDX_W'(item.bin_index);
        unique case (item.func)
            FUNC_PUSH:  entry_new.op = OP_PUSH;
            FUNC_READ:  entry_new.op = (item.bin_index <= BIN_W'(HALF)) ? OP_READ : OP_READ_ZERO;
            FUNC_CLEAR: entry_new.op = OP_CLEAR;
            default:
            begin
                // unused code: drop the word
                entry_new.op = OP_PUSH;
                keep = 1'b0;
            end
        endcase
    end

    assign enq = accept && keep;
    assign deq = stat.take && (count_reg != '0);

    always_comb
    begin
        head_next  = deq ? head_reg + 1'b1 : head_reg;
        tail_next  = enq ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg + QCNT_W'(enq) - QCNT_W'(deq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[tail_reg] <= entry_new;
        end
    end

    assign cmd.valid = (count_reg != '0);
    assign cmd.entry = q_reg[head_reg];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("command queue over depth");

    a_drop_unused: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.func != FUNC_PUSH && item.func != FUNC_READ
            && item.func != FUNC_CLEAR && !deq |=> $stable(count_reg))
        else $error("unused function code was queued");

    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stat.take |-> count_reg != '0)
        else $error("back end took from an empty queue");

endmodule

FILE: sv/wfpa_back.sv
`timescale 1ns / 1ps
// Back end: sample ring, windowing, radix-2 FFT with one butterfly unit,
// power accumulation and the result register. Depends on wfpa_pkg.
module wfpa_back
    import wfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output back_stat_t stat,
    input  logic       cfg_valid,
    input  logic [1:0] cfg_data,
    output out_item_t  result,
    output logic       res_valid,
    input  logic       res_pop
);

    typedef enum logic [13:0] {
        ST_INIT   = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_CLR    = 14'b00000000000100,
        ST_RD     = 14'b00000000001000,
        ST_LD_RD  = 14'b00000000010000,
        ST_LD_MUL = 14'b00000000100000,
        ST_LD_WR  = 14'b00000001000000,
        ST_BF_RD  = 14'b00000010000000,
        ST_BF_MUL = 14'b00000100000000,
        ST_BF_WP  = 14'b00001000000000,
        ST_BF_WQ  = 14'b00010000000000,
        ST_AC_RD  = 14'b00100000000000,
        ST_AC_SQ  = 14'b01000000000000,
        ST_AC_WR  = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [15:0] sample_mem [FFT_SIZE];
    logic [63:0] work_mem   [FFT_SIZE];
    logic [63:0] pow_mem    [BINS];

    logic [15:0] samp_q;
    logic [63:0] work_qa;
    logic [63:0] work_qb;
    logic [63:0] pow_q;

    logic             samp_we;
    logic             work_we;
    logic [IDX_W-1:0] work_waddr;
    logic [63:0]      work_wdata;
    logic [IDX_W-1:0] work_ra;
    logic [IDX_W-1:0] work_rb;
    logic             pow_we;
    logic [IDX_W-1:0] pow_waddr;
    logic [63:0]      pow_wdata;
    logic [IDX_W-1:0] pow_raddr;

    logic [1:0]               kind_reg;
    logic [IDX_W-1:0]         wpos_reg;
    logic [IDX_W-1:0]         wpos_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [15:0]       mean_reg;
    logic signed [15:0]       mean_next;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cnt_next;
    logic [STAGE_W-1:0]       stage_reg;
    logic [STAGE_W-1:0]       stage_next;
    logic [HALF_W-1:0]        bf_reg;
    logic [HALF_W-1:0]        bf_next;
    logic                     take;

    logic [16:0]              win_reg;
    logic signed [34:0]       prod_reg;
    logic signed [16:0]       wr_reg;
    logic signed [16:0]       wi_reg;
    logic [63:0]              a_reg;
    logic signed [48:0]       prr_reg;
    logic signed [48:0]       pii_reg;
    logic signed [48:0]       pri_reg;
    logic signed [48:0]       pir_reg;
    logic [63:0]              qv_reg;
    logic [63:0]              re2_reg;
    logic [63:0]              im2_reg;
    logic [63:0]              pw_reg;

    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    logic      slot_free;

    // butterfly addressing
    logic [HALF_W-1:0] bf_mask;
    logic [HALF_W-1:0] bf_j;
    logic [IDX_W-1:0]  bf_p;
    logic [IDX_W-1:0]  bf_q;
    logic [HALF_W-1:0] tw_k;

    logic signed [16:0] d_val;
    logic signed [34:0] prod_rnd;
    logic signed [31:0] x_val;
    logic signed [49:0] tr_wide;
    logic signed [49:0] ti_wide;
    logic signed [31:0] tr;
    logic signed [31:0] ti;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
    logic signed [31:0] ac_re;
    logic signed [31:0] ac_im;
    logic [63:0]        pwr;
    logic [63:0]        limit;

    assign bf_mask = HALF_W'((1 << stage_reg) - 1);
    assign bf_j    = bf_reg & bf_mask;
    assign bf_p    = ({1'b0, bf_reg & ~bf_mask} << 1) | {1'b0, bf_j};
    assign bf_q    = bf_p | (IDX_W'(1) << stage_reg);
    assign tw_k    = HALF_W'(bf_j << (STAGE_W'(LOG_SIZE - 1) - stage_reg));

    assign d_val    = 17'(signed'(samp_q)) - 17'(mean_reg);
    assign prod_rnd = (prod_reg + 35'sd16384) >>> 15;
    assign x_val    = 32'(prod_rnd);

    assign ar = signed'(a_reg[63:32]);
    assign ai = signed'(a_reg[31:0]);
    assign br = signed'(work_qb[63:32]);
    assign bi = signed'(work_qb[31:0]);
    assign tr_wide = 50'(prr_reg) - 50'(pii_reg) + 50'sd16384;
    assign ti_wide = 50'(pri_reg) + 50'(pir_reg) + 50'sd16384;
    assign tr = 32'(tr_wide >>> 15);
    assign ti = 32'(ti_wide >>> 15);

    assign ac_re = signed'(work_qa[63:32]);
    assign ac_im = signed'(work_qa[31:0]);
    assign pwr   = re2_reg + im2_reg;
    assign limit = {1'b0, POWER_MAX} - pwr;

    assign sum_add   = sum_reg + SUM_W'(signed'(cmd.entry.sample));
    assign slot_free = !res_valid_reg || res_pop;

    always_comb
    begin
        state_next     = state_reg;
        wpos_next      = wpos_reg;
        sum_next       = sum_reg;
        mean_next      = mean_reg;
        cnt_next       = cnt_reg;
        stage_next     = stage_reg;
        bf_next        = bf_reg;
        take           = 1'b0;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_pop;
        samp_we        = 1'b0;
        work_we        = 1'b0;
        work_waddr     = bf_p;
        work_wdata     = qv_reg;
        work_ra        = bf_p;
        work_rb        = bf_q;
        pow_we         = 1'b0;
        pow_waddr      = cnt_reg;
        pow_wdata      = '0;
        pow_raddr      = cmd.entry.bin;

        unique case (state_reg)
            ST_INIT, ST_CLR:
            begin
                pow_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(BINS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (cmd.entry.op)
                        OP_PUSH:
                        begin
                            take      = 1'b1;
                            samp_we   = 1'b1;
                            wpos_next = wpos_reg + 1'b1;
                            sum_next  = sum_add;
                            if (wpos_reg == IDX_W'(FFT_SIZE - 1))
                            begin
                                // frame complete: floor mean, restart the sum
                                mean_next  = 16'(sum_add >>> LOG_SIZE);
                                sum_next   = '0;
                                cnt_next   = '0;
                                state_next = ST_LD_RD;
                            end
                        end
                        OP_READ:
                        begin
                            if (slot_free)
                            begin
                                take       = 1'b1;
                                state_next = ST_RD;
                            end
                        end
                        OP_READ_ZERO:
                        begin
                            if (slot_free)
                            begin
                                take           = 1'b1;
                                res_next       = '0;
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            take       = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_CLR;
                        end
                        default:
                        begin
                            take = 1'b0;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                res_next.power     = pow_q[POW_W-1:0];
                res_next.saturated = pow_q[63];
                res_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_LD_RD:
            begin
                state_next = ST_LD_MUL;
            end
            ST_LD_MUL:
            begin
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                work_we    = 1'b1;
                work_waddr = bit_rev(cnt_reg);
                work_wdata = {x_val, 32'd0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(FFT_SIZE - 1))
                begin
                    stage_next = '0;
                    bf_next    = '0;
                    state_next = ST_BF_RD;
                end
                else
                begin
                    state_next = ST_LD_RD;
                end
            end
            ST_BF_RD:
            begin
                state_next = ST_BF_MUL;
            end
            ST_BF_MUL:
            begin
                state_next = ST_BF_WP;
            end
            ST_BF_WP:
            begin
                work_we    = 1'b1;
                work_waddr = bf_p;
                work_wdata = {32'(ar + tr), 32'(ai + ti)};
                state_next = ST_BF_WQ;
            end
            ST_BF_WQ:
            begin
                work_we    = 1'b1;
                work_waddr = bf_q;
                work_wdata = qv_reg;
                bf_next    = bf_reg + 1'b1;
                state_next = ST_BF_RD;
                if (bf_reg == HALF_W'(HALF - 1))
                begin
                    stage_next = stage_reg + 1'b1;
                    if (stage_reg == STAGE_W'(LOG_SIZE - 1))
                    begin
                        cnt_next   = IDX_W'(1);
                        state_next = ST_AC_RD;
                    end
                end
            end
            ST_AC_RD:
            begin
                work_ra    = cnt_reg;
                pow_raddr  = cnt_reg;
                state_next = ST_AC_SQ;
            end
            ST_AC_SQ:
            begin
                state_next = ST_AC_WR;
            end
            ST_AC_WR:
            begin
                pow_we = 1'b1;
                if ({1'b0, pw_reg[POW_W-1:0]} >= limit)
                begin
                    pow_wdata = {1'b1, POWER_MAX};
                end
                else
                begin
                    pow_wdata = {pw_reg[63], POW_W'({1'b0, pw_reg[POW_W-1:0]} + pwr)};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(HALF))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_AC_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            kind_reg      <= WIN_HANN;
            wpos_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            bf_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wpos_reg      <= wpos_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            bf_reg        <= bf_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid)
            begin
                kind_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        res_reg  <= res_next;
        if (state_reg == ST_LD_RD)
        begin
            win_reg <= win_at(kind_reg, cnt_reg);
        end
        if (state_reg == ST_LD_MUL)
        begin
            prod_reg <= 35'(d_val) * 35'(signed'({1'b0, win_reg}));
        end
        if (state_reg == ST_BF_RD)
        begin
            wr_reg <= signed'(TW_TAB[tw_k][33:17]);
            wi_reg <= signed'(TW_TAB[tw_k][16:0]);
        end
        if (state_reg == ST_BF_MUL)
        begin
            a_reg   <= work_qa;
            prr_reg <= 49'(br) * 49'(wr_reg);
            pii_reg <= 49'(bi) * 49'(wi_reg);
            pri_reg <= 49'(br) * 49'(wi_reg);
            pir_reg <= 49'(bi) * 49'(wr_reg);
        end
        if (state_reg == ST_BF_WP)
        begin
            qv_reg <= {32'(ar - tr), 32'(ai - ti)};
        end
        if (state_reg == ST_AC_SQ)
        begin
            re2_reg <= 64'(64'(ac_re) * 64'(ac_re));
            im2_reg <= 64'(64'(ac_im) * 64'(ac_im));
            pw_reg  <= pow_q;
        end
    end

    // memories, registered read
    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            sample_mem[wpos_reg] <= cmd.entry.sample;
        end
        samp_q <= sample_mem[cnt_reg];
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        work_qa <= work_mem[work_ra];
        work_qb <= work_mem[work_rb];
        if (pow_we)
        begin
            pow_mem[pow_waddr] <= pow_wdata;
        end
        pow_q <= pow_mem[pow_raddr];
    end

    assign stat.take      = take;
    assign stat.init_busy = (state_reg == ST_INIT);
    assign result         = res_reg;
    assign res_valid      = res_valid_reg;

    a_init_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> !take)
        else $error("command taken during clearing pass");

    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_RD || $past(state_reg) == ST_IDLE)
        else $error("result loaded outside a read");

    a_bin_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_AC_WR |-> cnt_reg != '0 && cnt_reg <= IDX_W'(HALF))
        else $error("accumulation outside bins one to half size");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == ST_IDLE && cmd.valid)
        else $error("command taken while busy");

endmodule

FILE: sv/windowed_fft_power_accumulator_top.sv
`timescale 1ns / 1ps
// Top level: input queue front end, FFT back end, result register.
// Depends on wfpa_pkg, wfpa_front, wfpa_back.
// Frames: every 1024th push runs a frame of load, butterfly and accumulate passes in the back end,
// which takes no commands meanwhile; the sustained sample rate is set by the single butterfly
// unit and its one work-store write port.
// Reads: a read word goes through the ST_RD state to the result register; a read of a bin above
// half size loads a zero result straight from the idle state.
// Reset: asynchronous; a clearing pass of the power sums follows, with full high.
// A clear command runs the same pass; the four-word queue keeps taking words meanwhile.
module windowed_fft_power_accumulator_top
    import wfpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);

    cmd_t       cmd;
    back_stat_t stat;
    logic       res_valid;

    wfpa_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .stat  (stat),
        .cmd   (cmd)
    );

    wfpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .result    (result),
        .res_valid (res_valid),
        .res_pop   (pop && res_valid)
    );

    assign cfg_ready = 1'b1;
    assign empty     = !res_valid;

endmodule

FILE: tb/sv/windowed_fft_power_accumulator_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for windowed_fft_power_accumulator_top: pushes, bin reads, clears.
// Carries its own fixed-point spectrum predictor; depends on wfpa_pkg and the top level.
module windowed_fft_power_accumulator_top_tb;
    import wfpa_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 30000;   // one frame plus a few queued clears
    localparam int CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = '0;

    windowed_fft_power_accumulator_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    in_item_t pending_words[$];
    out_item_t expected_power[$];
    int send_idle = 0;
    int recv_idle = 0;
    int mismatches = 0;
    longint cycles = 0;

    // spectrum predictor state
    logic signed [15:0] ring[FFT_SIZE];
    int unsigned ring_pos;
    longint work_re[FFT_SIZE];
    longint work_im[FFT_SIZE];
    logic [POW_W-1:0] bin_sum[BINS];
    bit bin_sat[BINS];
    logic [1:0] window_sel;
    longint window_rom[3][FFT_SIZE];
    longint twiddle_cos[HALF];
    longint twiddle_nsin[HALF];
    longint arc_step[CORDIC_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q2.30 cosine of a binary angle by rotation
    function automatic longint rotate_cos(bit [31:0] ang);
        bit [31:0] quarter;
        bit [31:0] a;
        bit neg;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        quarter = ang + 32'h4000_0000;
        neg = quarter[31];
        a = neg ? ang + 32'h8000_0000 : ang;
        z = longint'(int'(a));
        x = 652032874;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = x >>> k;
            dy = y >>> k;
            if (z >= 0)
            begin
                x -= dy; y += dx; z -= arc_step[k];
            end
            else
            begin
                x += dy; y -= dx; z += arc_step[k];
            end
        end
        return neg ? -x : x;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int reverse_index(int v);
        int r;
        r = 0;
        for (int k = 0; k < LOG_SIZE; k++)
            r = (r << 1) | ((v >> k) & 1);
        return r;
    endfunction

    task automatic build_tables();
        bit [31:0] t;
        longint c1;
        longint c2;
        longint c3;
        longint v[3];
        for (int i = 0; i < HALF; i++)
        begin
            t = 32'(64'(i) << (32 - LOG_SIZE));
            twiddle_cos[i] = limit((rotate_cos(t) + 16384) >>> 15, -32768, 32768);
            twiddle_nsin[i] = limit((rotate_cos(t + 32'h4000_0000) + 16384) >>> 15,
                                    -32768, 32768);
        end
        for (int i = 0; i < FFT_SIZE; i++)
        begin
            t = 32'((64'(i) << 32) / 64'(FFT_SIZE - 1));
            c1 = rotate_cos(t);
            c2 = rotate_cos(t * 2);
            c3 = rotate_cos(t * 3);
            v[0] = 64'sd536870912 * 64'sd1073741824 - 64'sd536870912 * c1;
            v[1] = 64'sd579820585 * 64'sd1073741824 - 64'sd493921239 * c1;
            v[2] = 64'sd385204879 * 64'sd1073741824 - 64'sd524297395 * c1
                 + 64'sd151698245 * c2 - 64'sd12541305 * c3;
            for (int w = 0; w < 3; w++)
                window_rom[w][i] = limit((v[w] + (64'sd1 <<< 44)) >>> 45, 0, 32768);
        end
    endtask

    task automatic run_frame();
        longint total;
        longint mean;
        longint wr;
        longint wi;
        longint tr;
        longint ti;
        longint ar;
        longint ai;
        longint pw;
        int sel;
        int half_len;
        int stride;
        int p;
        int q;
        sel = (window_sel == WIN_HAMMING) ? 1 : ((window_sel == WIN_BH) ? 2 : 0);
        total = 0;
        for (int i = 0; i < FFT_SIZE; i++)
            total += ring[i];
        mean = total >>> LOG_SIZE;
        for (int i = 0; i < FFT_SIZE; i++)
        begin
            work_re[reverse_index(i)] = ((ring[i] - mean) * window_rom[sel][i] + 16384) >>> 15;
            work_im[reverse_index(i)] = 0;
        end
        for (int len = 2; len <= FFT_SIZE; len <<= 1)
        begin
            half_len = len / 2;
            stride = FFT_SIZE / len;
            for (int base = 0; base < FFT_SIZE; base += len)
                for (int j = 0; j < half_len; j++)
                begin
                    p = base + j;
                    q = p + half_len;
                    wr = twiddle_cos[(j * stride) & (HALF - 1)];
                    wi = twiddle_nsin[(j * stride) & (HALF - 1)];
                    tr = (work_re[q] * wr - work_im[q] * wi + 16384) >>> 15;
                    ti = (work_re[q] * wi + work_im[q] * wr + 16384) >>> 15;
                    ar = work_re[p];
                    ai = work_im[p];
                    work_re[p] = ar + tr; work_im[p] = ai + ti;
                    work_re[q] = ar - tr; work_im[q] = ai - ti;
                end
        end
        for (int i = 1; i < BINS; i++)
        begin
            pw = work_re[i] * work_re[i] + work_im[i] * work_im[i];
            if ({1'b0, bin_sum[i]} >= {1'b0, POWER_MAX} - 64'(pw))
            begin
                bin_sum[i] = POWER_MAX;
                bin_sat[i] = 1'b1;
            end
            else
                bin_sum[i] = bin_sum[i] + POW_W'(pw);
        end
    endtask

    task automatic apply_word(in_item_t w);
        out_item_t r;
        case (w.func)
            FUNC_PUSH:
            begin
                ring[ring_pos] = w.sample;
                ring_pos = (ring_pos + 1) % FFT_SIZE;
                if (ring_pos == 0)
                    run_frame();
            end
            FUNC_READ:
            begin
                r = '0;
                if (w.bin_index < BINS)
                begin
                    r.power = bin_sum[w.bin_index];
                    r.saturated = bin_sat[w.bin_index];
                end
                expected_power.push_back(r);
            end
            FUNC_CLEAR:
            begin
                foreach (bin_sum[i])
                begin
                    bin_sum[i] = '0;
                    bin_sat[i] = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // driver: hold the word until accepted, then advance or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                apply_word(item);
            if (!push || !full)
            begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    item <= pending_words.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: compare each popped word with the oldest expectation
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_power.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: power=%0d saturated=%0b",
                                 result.power, result.saturated);
                end
                else
                begin
                    if (result.power !== expected_power[0].power ||
                        result.saturated !== expected_power[0].saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: power exp %0d got %0d, saturated exp %0b got %0b",
                                     expected_power[0].power, result.power,
                                     expected_power[0].saturated, result.saturated);
                    end
                    void'(expected_power.pop_front());
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    function automatic in_item_t make_word(logic [1:0] f, logic signed [15:0] s, int b);
        in_item_t w;
        w.func = f;
        w.sample = s;
        w.bin_index = BIN_W'(b);
        return w;
    endfunction

    task automatic queue_random(int count);
        int pick;
        int b;
        logic signed [15:0] s;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            b = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(1, HALF);
            case ($urandom_range(0, 9))
                0: s = 16'sh7FFF;
                1: s = -16'sh8000;
                2: s = 16'($signed($urandom_range(0, 511)) - 256);
                default: s = 16'($urandom);
            endcase
            if (pick < 84)
                pending_words.push_back(make_word(FUNC_PUSH, s, $urandom_range(0, 1023)));
            else if (pick < 97)
                pending_words.push_back(make_word(FUNC_READ, s, b));
            else if (pick < 98)
                pending_words.push_back(make_word(FUNC_CLEAR, s, b));
            else
                pending_words.push_back(make_word(FUNC_UNUSED, s, b));
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending_words.size() > 0 || push || expected_power.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_window(logic [1:0] kind);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= kind;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        window_sel = kind;
    endtask

    initial
    begin
        ring_pos = 0;
        window_sel = WIN_HANN;
        foreach (bin_sum[i])
        begin
            bin_sum[i] = '0;
            bin_sat[i] = 1'b0;
        end
        build_tables();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_window(WIN_BH);

        // directed: extremes, every function, bin edge cases
        pending_words.push_back(make_word(FUNC_READ, 0, 0));
        pending_words.push_back(make_word(FUNC_READ, 0, 1));
        pending_words.push_back(make_word(FUNC_READ, 0, HALF));
        pending_words.push_back(make_word(FUNC_READ, 0, HALF + 1));
        pending_words.push_back(make_word(FUNC_READ, -16'sh8000, 1023));
        pending_words.push_back(make_word(FUNC_PUSH, 16'sh7FFF, 1023));
        pending_words.push_back(make_word(FUNC_PUSH, -16'sh8000, 0));
        pending_words.push_back(make_word(FUNC_PUSH, 0, 0));
        pending_words.push_back(make_word(FUNC_PUSH, -16'sh1, 0));
        pending_words.push_back(make_word(FUNC_UNUSED, 16'sh1234, 5));
        pending_words.push_back(make_word(FUNC_READ, 0, 5));
        pending_words.push_back(make_word(FUNC_CLEAR, 0, 0));
        pending_words.push_back(make_word(FUNC_READ, 0, 2));
        pending_words.push_back(make_word(FUNC_PUSH, 16'sh5555, 0));
        pending_words.push_back(make_word(FUNC_PUSH, -16'sh5556, 0));
        drain();

        write_window(WIN_HANN);
        send_idle = 32;
        recv_idle = 54;
        queue_random(380);
        drain();   // hold the sender until every result is back
        queue_random(380);
        drain();

        write_window(2'd3);
        send_idle = 54;
        recv_idle = 32;
        queue_random(400);
        drain();

        write_window(WIN_HAMMING);
        send_idle = 0;
        recv_idle = 0;
        queue_random(400);
        drain();
        repeat (100) @(posedge clk);

        if (mismatches == 0 && expected_power.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/wfpa_pkg.sv
sv/wfpa_front.sv
sv/wfpa_back.sv
sv/windowed_fft_power_accumulator_top.sv
tb/sv/windowed_fft_power_accumulator_top_tb.sv
